[hw/rtl/sstd_pkg.sv]
// package for the seven-segment text display core
// types, action codes, font table; used by the cell and the top level
package sstd_pkg;

    localparam int MaxDigits = 8;
    localparam logic [7:0] DotBit = 8'h80;
    localparam logic [7:0] SegBits = 8'h7f;

    typedef enum logic [2:0] {
        ACT_WRITE = 3'd0,
        ACT_GLYPH = 3'd1,
        ACT_DOT   = 3'd2,
        ACT_CLEAR = 3'd3,
        ACT_CLRALL = 3'd4,
        ACT_PRINT = 3'd5,
        ACT_NOP6  = 3'd6,
        ACT_NOP7  = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  char_code;
        logic [2:0]  position;
        logic        dot_on;
        logic [15:0] number_value;
        logic [4:0]  radix;
    } t_in_item;

    typedef struct packed {
        logic [63:0] display_image;
        logic [3:0]  cursor_pos;
    } t_out_item;

    // command broadcast to every digit cell
    typedef struct packed {
        logic       shift;   // take neighbor segments, keep dot
        logic       put;     // glyph write at selected cell
        logic       dot;     // dot write at selected cell
        logic       dot_val;
        logic       clr_seg;
        logic       clr_all;
        logic [2:0] sel;
        logic [7:0] glyph;
    } t_cell_cmd;

    function automatic logic [7:0] font(input logic [6:0] code);
        logic [7:0] f;
        case (code[6:3])
            4'd0: f = 8'h00;
            default: f = 8'h00;
        endcase
        case (code)
            7'h00: f = 8'h3F; 7'h01: f = 8'h06; 7'h02: f = 8'h5B; 7'h03: f = 8'h4F;
            7'h04: f = 8'h66; 7'h05: f = 8'h6D; 7'h06: f = 8'h7D; 7'h07: f = 8'h07;
            7'h08: f = 8'h7F; 7'h09: f = 8'h6F; 7'h0a: f = 8'h77; 7'h0b: f = 8'h7C;
            7'h0c: f = 8'h39; 7'h0d: f = 8'h5E; 7'h0e: f = 8'h79; 7'h0f: f = 8'h71;
            7'h10: f = 8'h01; 7'h11: f = 8'h02; 7'h12: f = 8'h04; 7'h13: f = 8'h08;
            7'h14: f = 8'h10; 7'h15: f = 8'h20; 7'h16: f = 8'h40; 7'h17: f = 8'h80;
            7'h18: f = 8'h11; 7'h19: f = 8'h22; 7'h1a: f = 8'h44; 7'h1b: f = 8'h88;
            7'h1c: f = 8'h11; 7'h1d: f = 8'h22; 7'h1e: f = 8'h44; 7'h1f: f = 8'h88;
            7'h2d: f = 8'h40;
            7'h30: f = 8'h3F; 7'h31: f = 8'h06; 7'h32: f = 8'h5B; 7'h33: f = 8'h4F;
            7'h34: f = 8'h66; 7'h35: f = 8'h6D; 7'h36: f = 8'h7D; 7'h37: f = 8'h07;
            7'h38: f = 8'h7F; 7'h39: f = 8'h6F;
            7'h41: f = 8'h77; 7'h42: f = 8'h7C; 7'h43: f = 8'h39; 7'h44: f = 8'h5E;
            7'h45: f = 8'h79; 7'h46: f = 8'h71; 7'h47: f = 8'h3D; 7'h48: f = 8'h76;
            7'h49: f = 8'h30; 7'h4a: f = 8'h0E; 7'h4c: f = 8'h38; 7'h4d: f = 8'h37;
            7'h4e: f = 8'h54; 7'h4f: f = 8'h3F; 7'h50: f = 8'h73; 7'h51: f = 8'h67;
            7'h52: f = 8'h50; 7'h53: f = 8'h6D; 7'h54: f = 8'h70; 7'h55: f = 8'h3E;
            7'h56: f = 8'h38; 7'h57: f = 8'h74; 7'h58: f = 8'h52; 7'h59: f = 8'h66;
            7'h5a: f = 8'h5B; 7'h5b: f = 8'h39; 7'h5d: f = 8'h0F; 7'h5f: f = 8'h08;
            7'h61: f = 8'h77; 7'h62: f = 8'h7C; 7'h63: f = 8'h58; 7'h64: f = 8'h5E;
            7'h65: f = 8'h79; 7'h66: f = 8'h71; 7'h67: f = 8'h6F; 7'h68: f = 8'h74;
            7'h69: f = 8'h10; 7'h6a: f = 8'h0E; 7'h6c: f = 8'h30; 7'h6d: f = 8'h37;
            7'h6e: f = 8'h54; 7'h6f: f = 8'h5C; 7'h70: f = 8'h73; 7'h71: f = 8'h67;
            7'h72: f = 8'h50; 7'h73: f = 8'h6D; 7'h74: f = 8'h70; 7'h75: f = 8'h1C;
            7'h76: f = 8'h38; 7'h77: f = 8'h74; 7'h78: f = 8'h52; 7'h79: f = 8'h6E;
            7'h7a: f = 8'h5B; 7'h7c: f = 8'h30;
            default: f = 8'h00;
        endcase
        return f;
    endfunction

endpackage

[hw/rtl/sstd_cell.sv]
// one display digit: segment and dot register
// depends on sstd_pkg for the cell command struct
module sstd_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [2:0]          i_index,
    input  logic                i_in_use,
    input  logic                i_shift_en,
    input  sstd_pkg::t_cell_cmd i_cmd,
    input  logic [6:0]          i_right_seg,
    output logic [7:0]          o_digit
);

    logic [7:0] r_digit;
    logic [7:0] n_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_in_use) begin
            if (i_cmd.clr_all) begin
                n_digit = 8'h00;
            end else if (i_cmd.clr_seg) begin
                n_digit = r_digit & sstd_pkg::DotBit;
            end else if (i_cmd.shift && i_shift_en) begin
                n_digit = {r_digit[7], i_right_seg};
            end else if (i_cmd.put && i_cmd.sel == i_index) begin
                n_digit = (r_digit & sstd_pkg::DotBit) | i_cmd.glyph;
            end else if (i_cmd.dot && i_cmd.sel == i_index) begin
                n_digit = {i_cmd.dot_val, r_digit[6:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= 8'h00;
        end else begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

[hw/rtl/sstd_radix_div.sv]
// iterative radix digit extractor: one digit per pass, restoring division
// depends on no other file; does not use sstd_pkg
module sstd_radix_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_value,
    input  logic [4:0]  i_radix,
    output logic        o_done,
    output logic [3:0]  o_rem,
    output logic [15:0] o_quot
);

    logic [15:0] r_q;
    logic [4:0]  r_rem;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [5:0]  w_trial;
    logic [4:0]  n_rem;

    always_comb begin
        w_trial = {r_rem, r_q[15]};
        n_rem = w_trial[4:0];
        if (w_trial >= {1'b0, i_radix}) begin
            n_rem = 5'(w_trial - {1'b0, i_radix});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd15) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_value;
            r_rem <= 5'd0;
        end else if (r_busy) begin
            r_q   <= {r_q[14:0], (w_trial >= {1'b0, i_radix})};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_busy && r_cnt == 5'd15;
    // results valid in the cycle after o_done
    assign o_rem  = r_rem[3:0];
    assign o_quot = r_q;

endmodule

[hw/rtl/seven_segment_text_display_core.sv]
// top level of the seven-segment text display core
// depends on sstd_pkg, sstd_cell, sstd_radix_div
//
// usage:
//   i_cfg_valid/o_cfg_ready write digits_in_use (4 bits); ready is always high.
//   i_in_valid/o_in_ready take one action item (t_in_item).
//   o_out_valid/i_out_ready deliver the display image and cursor per item.
// simple actions give a registered result in the cycle after acceptance.
//   print takes digits_in_use passes of the radix divider (one quotient bit
//   per cycle), then one emit step per digit and a final output state.
// throughput: one item at a time; a new item is taken once the previous
//   result has left the output register, so a stalled receiver holds input.
// the digits are a row of cells; a scroll moves segments one cell left
//   from neighbor to neighbor, dots stay in place.
// reset: all digits zero, cursor zero, digits_in_use 8, output empty.
module seven_segment_text_display_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [3:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sstd_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sstd_pkg::t_out_item o_out_item
);

    localparam int Nd = sstd_pkg::MaxDigits;

    sstd_pkg::t_state    r_state, n_state;
    logic [3:0]          r_diu;
    logic [3:0]          r_cursor, n_cursor;
    logic [3:0]          w_used;
    logic [7:0]          w_digit [Nd];
    sstd_pkg::t_cell_cmd w_cmd;
    logic                r_out_valid;
    logic [3:0]          r_stack [Nd];
    logic [3:0]          r_idx;
    logic                r_started;
    logic [4:0]          r_radix;
    logic                w_div_start, w_div_done, r_div_fin;
    logic [3:0]          w_rem;
    logic [15:0]         w_quot;
    logic                w_take;
    logic                w_wr;
    logic [6:0]          w_wr_code;
    logic [63:0]         w_image;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diu <= 4'd8;
        end else if (i_cfg_valid) begin
            r_diu <= i_cfg_data;
        end
    end

    always_comb begin
        w_used = r_diu;
        if (r_diu == 4'd0) w_used = 4'd1;
        if (r_diu > 4'(Nd)) w_used = 4'(Nd);
    end

    assign o_in_ready = (r_state == sstd_pkg::ST_IDLE) && !r_out_valid;
    assign w_take = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            sstd_pkg::ST_IDLE: begin
                if (w_take && i_in_item.action == sstd_pkg::ACT_PRINT) n_state = sstd_pkg::ST_DIV;
            end
            sstd_pkg::ST_DIV: begin
                if (r_div_fin && r_idx == w_used - 4'd1) n_state = sstd_pkg::ST_EMIT;
            end
            sstd_pkg::ST_EMIT: begin
                if (r_idx == 4'd0) n_state = sstd_pkg::ST_OUT;
            end
            sstd_pkg::ST_OUT: n_state = sstd_pkg::ST_IDLE;
            default: n_state = sstd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sstd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // divider sequencing; each later pass divides the previous quotient
    assign w_div_start = (w_take && i_in_item.action == sstd_pkg::ACT_PRINT) ||
                         (r_state == sstd_pkg::ST_DIV && r_div_fin && r_idx != w_used - 4'd1);

    sstd_radix_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_value (w_take ? i_in_item.number_value : w_quot),
        .i_radix (w_take ? (i_in_item.radix < 5'd2 ? 5'd2 :
                            (i_in_item.radix > 5'd16 ? 5'd16 : i_in_item.radix)) : r_radix),
        .o_done  (w_div_done),
        .o_rem   (w_rem),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_fin <= 1'b0;
            r_idx     <= 4'd0;
            r_started <= 1'b0;
        end else begin
            r_div_fin <= w_div_done;
            if (w_take) begin
                r_idx     <= 4'd0;
                r_started <= 1'b0;
            end else if (r_state == sstd_pkg::ST_DIV && r_div_fin) begin
                if (r_idx != w_used - 4'd1) r_idx <= r_idx + 4'd1;
            end else if (r_state == sstd_pkg::ST_EMIT) begin
                if (r_stack[r_idx[2:0]] != 4'd0) r_started <= 1'b1;
                if (r_idx != 4'd0) r_idx <= r_idx - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_radix <= i_in_item.radix < 5'd2 ? 5'd2 :
                       (i_in_item.radix > 5'd16 ? 5'd16 : i_in_item.radix);
        end else if (r_state == sstd_pkg::ST_DIV && r_div_fin) begin
            r_stack[r_idx[2:0]] <= w_rem;
        end
    end

    // write-at-cursor request, from an item or from the print sequencer
    always_comb begin
        w_wr = 1'b0;
        w_wr_code = i_in_item.char_code[6:0];
        if (w_take && i_in_item.action == sstd_pkg::ACT_WRITE) begin
            w_wr = 1'b1;
        end else if (r_state == sstd_pkg::ST_EMIT) begin
            w_wr_code = {3'd0, r_stack[r_idx[2:0]]};
            w_wr = r_started || r_stack[r_idx[2:0]] != 4'd0 || r_idx == 4'd0;
        end
    end

    always_comb begin
        w_cmd = '0;
        w_cmd.glyph = sstd_pkg::font(w_wr_code);
        n_cursor = r_cursor;
        if (w_wr) begin
            if (r_cursor >= w_used) begin
                w_cmd.shift = 1'b1;
            end else begin
                w_cmd.put = 1'b1;
                w_cmd.sel = r_cursor[2:0];
                n_cursor = r_cursor + 4'd1;
            end
        end else if (w_take) begin
            case (i_in_item.action)
                sstd_pkg::ACT_GLYPH: begin
                    w_cmd.put = 1'b1;
                    w_cmd.sel = i_in_item.position;
                    w_cmd.glyph = sstd_pkg::font(i_in_item.char_code[6:0]);
                end
                sstd_pkg::ACT_DOT: begin
                    w_cmd.dot = 1'b1;
                    w_cmd.sel = i_in_item.position;
                    w_cmd.dot_val = i_in_item.dot_on;
                end
                sstd_pkg::ACT_CLEAR, sstd_pkg::ACT_PRINT: begin
                    w_cmd.clr_seg = 1'b1;
                    n_cursor = 4'd0;
                end
                sstd_pkg::ACT_CLRALL: begin
                    w_cmd.clr_all = 1'b1;
                    n_cursor = 4'd0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= 4'd0;
        end else begin
            r_cursor <= n_cursor;
        end
    end

    // cell row; the last digit in use takes the new glyph on a scroll
    for (genvar g = 0; g < Nd; g++) begin : g_cell
        sstd_pkg::t_cell_cmd w_c;
        logic [6:0] w_right;
        logic w_last;
        assign w_last = (4'(g) == w_used - 4'd1);
        always_comb begin
            w_c = w_cmd;
            if (w_cmd.shift && w_last) begin
                w_c.shift = 1'b0;
                w_c.put = 1'b1;
                w_c.sel = 3'(g);
            end
        end
        if (g == Nd - 1) begin : g_end
            assign w_right = 7'd0;
        end else begin : g_mid
            assign w_right = w_digit[g + 1][6:0];
        end
        sstd_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_index     (3'(g)),
            .i_in_use    (4'(g) < w_used),
            .i_shift_en  (!w_last),
            .i_cmd       (w_c),
            .i_right_seg (w_right),
            .o_digit     (w_digit[g])
        );
        assign w_image[8*g +: 8] = w_digit[g];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            r_out_valid <= 1'b0;
        end else if ((w_take && i_in_item.action != sstd_pkg::ACT_PRINT) ||
                     r_state == sstd_pkg::ST_OUT) begin
            r_out_valid <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item.display_image = w_image;
    assign o_out_item.cursor_pos = r_cursor;

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !o_in_ready) else $error("input taken while result pending");
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= 4'(Nd)) else $error("cursor out of range");
    a_print_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sstd_pkg::ST_OUT |=> r_out_valid) else $error("print result lost");

endmodule
